[hdl/tmpm_pkg.sv]
package tmpm_pkg;

  localparam int NODE_COUNT_DEF = 256;
  localparam int MAX_DEPTH_DEF  = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic RES_INSERT = 1'b0;
  localparam logic RES_MATCH  = 1'b1;

  localparam logic [1:0] INS_ADDED = 2'd0;
  localparam logic [1:0] INS_DUP   = 2'd1;
  localparam logic [1:0] INS_FULL  = 2'd2;
  localparam logic [1:0] INS_LONG  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_UPD,
    ST_FIN_RD,
    ST_FIN,
    ST_SEL,
    ST_CHILD,
    ST_INFO,
    ST_END
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic accept_ins;
    logic accept_srch;
    logic ins_rd;
    logic ins_upd;
    logic fin_rd;
    logic fin_commit;
    logic sel_skip;
    logic sel_rd;
    logic child_step;
    logic info_step;
    logic end_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last;
    logic top_live;
    logic k_zero;
    logic child_zero;
    logic info_final;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

[hdl/tmpm_req_if.sv]
interface tmpm_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, req_type, data_byte, last_byte, input ready);
  modport sink(input valid, req_type, data_byte, last_byte, output ready);
endinterface

[hdl/tmpm_res_if.sv]
interface tmpm_res_if;
  logic        valid;
  logic        ready;
  logic        res_kind;
  logic [1:0]  insert_status;
  logic [7:0]  pattern_total;
  logic [5:0]  match_length;
  logic [31:0] match_start;
  logic        run_last;

  modport source(output valid, res_kind, insert_status, pattern_total, match_length,
                 match_start, run_last, input ready);
  modport sink(input valid, res_kind, insert_status, pattern_total, match_length,
               match_start, run_last, output ready);
endinterface

[hdl/tmpm_ctrl.sv]
module tmpm_ctrl
  import tmpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_req_type,
  output logic    in_ready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   info_hold;

  assign info_hold = stat.info_final && stat.pend_valid && !stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (in_req_type == REQ_SEARCH) ? ST_SEL : ST_INS_RD;
      end
      ST_INS_RD:  state_next = ST_INS_UPD;
      ST_INS_UPD: state_next = stat.last ? ST_FIN_RD : ST_IDLE;
      ST_FIN_RD:  state_next = ST_FIN;
      ST_FIN: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      ST_SEL: begin
        if (stat.top_live) state_next = ST_CHILD;
        else state_next = stat.k_zero ? ST_END : ST_SEL;
      end
      ST_CHILD: begin
        if (!stat.child_zero) state_next = ST_INFO;
        else state_next = stat.k_zero ? ST_END : ST_SEL;
      end
      ST_INFO: begin
        if (!info_hold) state_next = stat.k_zero ? ST_END : ST_SEL;
      end
      ST_END: begin
        if (!stat.pend_valid || stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd             = '0;
    in_ready        = (state == ST_IDLE);
    cmd.clear_step  = (state == ST_CLEAR);
    cmd.accept_ins  = (state == ST_IDLE) && in_valid && (in_req_type == REQ_INSERT);
    cmd.accept_srch = (state == ST_IDLE) && in_valid && (in_req_type == REQ_SEARCH);
    cmd.ins_rd      = (state == ST_INS_RD);
    cmd.ins_upd     = (state == ST_INS_UPD);
    cmd.fin_rd      = (state == ST_FIN_RD);
    cmd.fin_commit  = (state == ST_FIN) && stat.out_free;
    cmd.sel_skip    = (state == ST_SEL) && !stat.top_live;
    cmd.sel_rd      = (state == ST_SEL) && stat.top_live;
    cmd.child_step  = (state == ST_CHILD);
    cmd.info_step   = (state == ST_INFO) && !info_hold;
    cmd.end_step    = (state == ST_END) && (!stat.pend_valid || stat.out_free);
  end

endmodule

[hdl/tmpm_dp.sv]
module tmpm_dp
  import tmpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        res_kind,
  output logic [1:0]  res_insert_status,
  output logic [7:0]  res_pattern_total,
  output logic [5:0]  res_match_length,
  output logic [31:0] res_match_start,
  output logic        res_run_last
);

  localparam int NW       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int AW       = NW + 8;
  localparam int CT_DEPTH = NODE_COUNT * 256;
  localparam int LW       = $clog2(MAX_DEPTH + 1);
  localparam int IW       = LW + 1;
  localparam int KW       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int TOP      = MAX_DEPTH - 1;

  logic [NW-1:0] ct_mem [CT_DEPTH];
  logic [IW-1:0] ni_mem [NODE_COUNT];

  logic          ct_we, ct_re, ni_we, ni_re;
  logic [AW-1:0] ct_waddr, ct_raddr;
  logic [NW-1:0] ct_wdata, ct_q;
  logic [NW-1:0] ni_waddr, ni_raddr;
  logic [IW-1:0] ni_wdata, ni_q;

  logic [AW-1:0] clr_cnt;
  logic [7:0]    byte_q;
  logic          last_q;
  logic [NW:0]   used;
  logic [7:0]    pcnt;
  logic [NW-1:0] cursor;
  logic [LW-1:0] ins_len;
  logic [1:0]    ins_fail;

  logic [NW-1:0] wnode [MAX_DEPTH];
  logic          wlive [MAX_DEPTH];
  logic [KW-1:0] k;
  logic [31:0]   tpos;

  logic          pend_valid;
  logic [LW-1:0] pend_len;
  logic [31:0]   pend_start;

  logic          out_free, create, ins_ok;
  logic [1:0]    fin_status;
  logic [7:0]    pcnt_new;
  logic          shift_en;
  logic [NW-1:0] shift_node;
  logic          shift_live;
  logic          push;
  logic          push_kind;
  logic [1:0]    push_status;
  logic [7:0]    push_total;
  logic [LW-1:0] push_len;
  logic [31:0]   push_start;
  logic          push_last;
  logic [LW+5:0] len_ext;
  logic [31:0]   cur_start;

  assign out_free  = !res_valid || res_ready;
  assign ins_ok    = (ins_fail == INS_ADDED) && (ins_len < LW'(MAX_DEPTH));
  assign create    = cmd.ins_upd && ins_ok && (ct_q == '0) && (used < (NW+1)'(NODE_COUNT));
  assign cur_start = tpos - 32'(k);

  always_comb begin
    fin_status = ins_fail;
    if (ins_fail == INS_ADDED && ni_q[IW-1]) fin_status = INS_DUP;
    pcnt_new = pcnt;
    if (ins_fail == INS_ADDED && !ni_q[IW-1] && pcnt != 8'hFF) pcnt_new = pcnt + 8'd1;
  end

  always_comb begin
    ct_we    = 1'b0;
    ct_waddr = {cursor, byte_q};
    ct_wdata = used[NW-1:0];
    ni_we    = 1'b0;
    ni_waddr = used[NW-1:0];
    ni_wdata = {1'b0, ins_len + LW'(1)};
    if (cmd.clear_step) begin
      ct_we    = 1'b1;
      ct_waddr = clr_cnt;
      ct_wdata = '0;
      ni_we    = (clr_cnt[7:0] == 8'd0);
      ni_waddr = clr_cnt[AW-1:8];
      ni_wdata = '0;
    end else if (create) begin
      ct_we = 1'b1;
      ni_we = 1'b1;
    end else if (cmd.fin_commit && fin_status == INS_ADDED && !ni_q[IW-1]) begin
      ni_we    = 1'b1;
      ni_waddr = cursor;
      ni_wdata = {1'b1, ni_q[LW-1:0]};
    end
    ct_re    = cmd.ins_rd || cmd.sel_rd;
    ct_raddr = cmd.sel_rd ? {wnode[TOP], byte_q} : {cursor, byte_q};
    ni_re    = cmd.fin_rd || (cmd.child_step && ct_q != '0);
    ni_raddr = cmd.fin_rd ? cursor : ct_q;
  end

  always_ff @(posedge clk) begin
    if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
    if (ct_re) ct_q <= ct_mem[ct_raddr];
  end

  always_ff @(posedge clk) begin
    if (ni_we) ni_mem[ni_waddr] <= ni_wdata;
    if (ni_re) ni_q <= ni_mem[ni_raddr];
  end

  always_comb begin
    shift_en   = 1'b0;
    shift_node = wnode[TOP];
    shift_live = wlive[TOP];
    if (cmd.accept_srch) begin
      shift_en   = 1'b1;
      shift_node = '0;
      shift_live = 1'b1;
    end else if (cmd.sel_skip) begin
      shift_en = 1'b1;
    end else if (cmd.child_step && ct_q == '0) begin
      shift_en   = 1'b1;
      shift_node = '0;
      shift_live = 1'b0;
    end else if (cmd.info_step) begin
      shift_en   = 1'b1;
      shift_node = ct_q;
      shift_live = 1'b1;
    end
  end

  always_comb begin
    push        = 1'b0;
    push_kind   = RES_MATCH;
    push_status = INS_ADDED;
    push_total  = 8'd0;
    push_len    = pend_len;
    push_start  = pend_start;
    push_last   = 1'b0;
    if (cmd.fin_commit) begin
      push        = 1'b1;
      push_kind   = RES_INSERT;
      push_status = fin_status;
      push_total  = pcnt_new;
      push_len    = '0;
      push_start  = '0;
      push_last   = 1'b1;
    end else if (cmd.info_step && ni_q[IW-1] && pend_valid) begin
      push = 1'b1;
    end else if (cmd.end_step && pend_valid) begin
      push      = 1'b1;
      push_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      used       <= (NW+1)'(1);
      pcnt       <= '0;
      cursor     <= '0;
      ins_len    <= '0;
      ins_fail   <= INS_ADDED;
      k          <= '0;
      tpos       <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
      for (int j = 0; j < MAX_DEPTH; j++) begin
        wnode[j] <= '0;
        wlive[j] <= 1'b0;
      end
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.accept_ins || cmd.accept_srch) begin
        byte_q <= in_data_byte;
        last_q <= in_last_byte;
      end
      if (cmd.ins_upd && ins_fail == INS_ADDED) begin
        if (ins_len >= LW'(MAX_DEPTH)) begin
          ins_fail <= INS_LONG;
        end else if (ct_q == '0) begin
          if (create) begin
            used    <= used + (NW+1)'(1);
            cursor  <= used[NW-1:0];
            ins_len <= ins_len + LW'(1);
          end else begin
            ins_fail <= INS_FULL;
          end
        end else begin
          cursor  <= ct_q;
          ins_len <= ins_len + LW'(1);
        end
      end
      if (cmd.fin_commit) begin
        pcnt     <= pcnt_new;
        cursor   <= '0;
        ins_len  <= '0;
        ins_fail <= INS_ADDED;
      end
      if (shift_en) begin
        for (int j = MAX_DEPTH - 1; j > 0; j--) begin
          wnode[j] <= wnode[j-1];
          wlive[j] <= wlive[j-1];
        end
        wnode[0] <= shift_node;
        wlive[0] <= shift_live;
      end
      if (cmd.accept_srch) k <= KW'(MAX_DEPTH - 1);
      else if (cmd.sel_skip || (cmd.child_step && ct_q == '0) || cmd.info_step) k <= k - KW'(1);
      if (cmd.info_step && ni_q[IW-1]) begin
        pend_valid <= 1'b1;
        pend_len   <= ni_q[LW-1:0];
        pend_start <= cur_start;
      end
      if (cmd.end_step) begin
        pend_valid <= 1'b0;
        if (last_q) begin
          tpos <= '0;
          for (int j = 0; j < MAX_DEPTH; j++) begin
            wnode[j] <= '0;
            wlive[j] <= 1'b0;
          end
        end else begin
          tpos <= tpos + 32'd1;
        end
      end
      if (push) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  assign len_ext = {6'd0, push_len};

  always_ff @(posedge clk) begin
    if (push) begin
      res_kind          <= push_kind;
      res_insert_status <= push_status;
      res_pattern_total <= push_total;
      res_match_length  <= len_ext[5:0];
      res_match_start   <= push_start;
      res_run_last      <= push_last;
    end
  end

  always_comb begin
    stat            = '0;
    stat.clear_last = (clr_cnt == AW'(CT_DEPTH - 1));
    stat.last       = last_q;
    stat.top_live   = wlive[TOP];
    stat.k_zero     = (k == '0);
    stat.child_zero = (ct_q == '0);
    stat.info_final = ni_q[IW-1];
    stat.pend_valid = pend_valid;
    stat.out_free   = out_free;
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= (NW+1)'(NODE_COUNT))
    else $error("node allocation ran past the table");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ins_len <= LW'(MAX_DEPTH))
    else $error("insert cursor deeper than the depth limit");
  a_create_count: assert property (@(posedge clk) disable iff (rst)
    create |=> used == $past(used) + (NW+1)'(1))
    else $error("node creation did not advance the allocator");
  a_end_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.end_step |=> !pend_valid)
    else $error("a match was left pending after the text byte finished");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("a waiting result beat was dropped");
`endif

endmodule

[hdl/trie_multi_pattern_matcher_top.sv]
// Insert byte: a transition table read (ST_INS_RD), then an update (ST_INS_UPD); a last
// insert byte adds a node info read (ST_FIN_RD) and the status beat (ST_FIN). Search byte:
// the walkers take turns at the single transition table read port; an idle one is skipped,
// a live one is read (ST_SEL, ST_CHILD) and, if it advances, also steps through ST_INFO.
// One byte at a time. Each match waits in a pending register until the next match or the
// end of the byte, and stalls only while the output register is full. Reset is synchronous;
// a clearing pass of NODE_COUNT*256 entries empties the transition table before any byte.
module trie_multi_pattern_matcher_top
  import tmpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  tmpm_req_if.sink   req,
  tmpm_res_if.source res
);

  cmd_t    cmd;
  status_t stat;

  tmpm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (req.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  tmpm_dp #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_data_byte      (req.data_byte),
    .in_last_byte      (req.last_byte),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_kind          (res.res_kind),
    .res_insert_status (res.insert_status),
    .res_pattern_total (res.pattern_total),
    .res_match_length  (res.match_length),
    .res_match_start   (res.match_start),
    .res_run_last      (res.run_last)
  );

endmodule

[tb/sv/trie_multi_pattern_matcher_top_test.sv]
module trie_multi_pattern_matcher_top_test;
  import tmpm_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int DEPTH = MAX_DEPTH_DEF;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
  } req_beat_t;

  typedef struct packed {
    logic        res_kind;
    logic [1:0]  insert_status;
    logic [7:0]  pattern_total;
    logic [5:0]  match_length;
    logic [31:0] match_start;
    logic        run_last;
  } res_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tmpm_req_if req();
  tmpm_res_if res();

  trie_multi_pattern_matcher_top dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .res(res.source)
  );

  always #10 clk = ~clk;

  logic [7:0]  trie_child [NODES*256];
  logic [5:0]  trie_depth [NODES];
  logic        trie_final [NODES];
  int unsigned trie_used;
  int unsigned stored_patterns;
  int unsigned ins_node;
  int unsigned ins_len;
  logic [1:0]  ins_fail;
  int unsigned walk_node [DEPTH];
  logic        walk_live [DEPTH];
  logic [31:0] text_pos;

  req_beat_t pending_beats[$];
  res_beat_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned match_beats = 0;
  int unsigned insert_beats = 0;
  int unsigned idle_cycles = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;

  task automatic predict_beat(input req_beat_t b);
    res_beat_t r;
    int unsigned child;
    int found;
    if (b.req_type == REQ_INSERT) begin
      if (ins_fail == INS_ADDED) begin
        if (ins_len >= DEPTH) begin
          ins_fail = INS_LONG;
        end else begin
          child = trie_child[ins_node*256 + b.data_byte];
          if (child == 0) begin
            if (trie_used >= NODES) begin
              ins_fail = INS_FULL;
            end else begin
              child = trie_used;
              trie_used++;
              trie_depth[child] = trie_depth[ins_node] + 6'd1;
              trie_final[child] = 1'b0;
              trie_child[ins_node*256 + b.data_byte] = child[7:0];
            end
          end
          if (ins_fail == INS_ADDED) begin
            ins_node = child;
            ins_len++;
          end
        end
      end
      if (b.last_byte) begin
        r = '0;
        r.res_kind = RES_INSERT;
        r.insert_status = ins_fail;
        if (ins_fail == INS_ADDED) begin
          if (trie_final[ins_node]) begin
            r.insert_status = INS_DUP;
          end else begin
            trie_final[ins_node] = 1'b1;
            if (stored_patterns < 255) stored_patterns++;
          end
        end
        r.pattern_total = stored_patterns[7:0];
        r.run_last = 1'b1;
        expected_results.push_back(r);
        ins_node = 0;
        ins_len = 0;
        ins_fail = INS_ADDED;
      end
    end else begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        walk_node[k] = walk_node[k-1];
        walk_live[k] = walk_live[k-1];
      end
      walk_node[0] = 0;
      walk_live[0] = 1'b1;
      found = 0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
        if (walk_live[k]) begin
          child = trie_child[walk_node[k]*256 + b.data_byte];
          if (child == 0) begin
            walk_live[k] = 1'b0;
            walk_node[k] = 0;
          end else begin
            walk_node[k] = child;
            if (trie_final[child] && found < DEPTH) begin
              r = '0;
              r.res_kind = RES_MATCH;
              r.match_length = trie_depth[child];
              r.match_start = text_pos - k;
              expected_results.push_back(r);
              found++;
            end
          end
        end
      end
      if (found > 0) expected_results[$].run_last = 1'b1;
      if (b.last_byte) begin
        for (int k = 0; k < DEPTH; k++) begin
          walk_node[k] = 0;
          walk_live[k] = 1'b0;
        end
        text_pos = '0;
      end else begin
        text_pos = text_pos + 32'd1;
      end
    end
  endtask

  task automatic queue_pattern(input byte unsigned s[$]);
    foreach (s[i]) pending_beats.push_back({REQ_INSERT, s[i], i == s.size() - 1});
  endtask

  task automatic queue_text(input byte unsigned s[$]);
    foreach (s[i]) pending_beats.push_back({REQ_SEARCH, s[i], i == s.size() - 1});
  endtask

  task automatic queue_random_item(input byte unsigned alphabet);
    byte unsigned s[$];
    int n;
    case ($urandom_range(9))
      0: begin
        n = $urandom_range(8, 1);
        repeat (n) s.push_back(8'($urandom_range(255)));
        if ($urandom_range(1)) queue_pattern(s); else queue_text(s);
      end
      1, 2, 3: begin
        n = $urandom_range(4, 1);
        repeat (n) s.push_back(8'($urandom_range(alphabet - 1) + 8'h61));
        queue_pattern(s);
      end
      default: begin
        n = $urandom_range(24, 1);
        repeat (n) s.push_back(8'($urandom_range(alphabet - 1) + 8'h61));
        queue_text(s);
      end
    endcase
  endtask

  initial begin
    byte unsigned s[$];
    for (int i = 0; i < NODES*256; i++) trie_child[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      trie_depth[i] = '0;
      trie_final[i] = 1'b0;
    end
    for (int k = 0; k < DEPTH; k++) begin
      walk_node[k] = 0;
      walk_live[k] = 1'b0;
    end
    trie_used = 1;
    stored_patterns = 0;
    ins_node = 0;
    ins_len = 0;
    ins_fail = INS_ADDED;
    text_pos = '0;

    s = '{8'h00}; queue_pattern(s);
    s = '{8'hff, 8'h00}; queue_pattern(s);
    s = '{8'h61, 8'h62}; queue_pattern(s);
    s = '{8'h61, 8'h62}; queue_pattern(s);
    s = '{8'h62}; queue_pattern(s);
    s = {}; repeat (DEPTH + 2) s.push_back(8'h7a); queue_pattern(s);
    s = {}; repeat (DEPTH) s.push_back(8'h7a); queue_pattern(s);
    s = '{8'h61, 8'h62, 8'h62, 8'h00, 8'hff}; queue_text(s);
    s = {}; repeat (DEPTH + 3) s.push_back(8'h7a); queue_text(s);
    s = '{8'h55}; queue_pattern(s);
    s = '{8'h62, 8'h61}; queue_text(s);

    while (pending_beats.size() < 140) queue_random_item(3);
    repeat (28) begin
      s = {};
      repeat (8) s.push_back(8'($urandom_range(255)));
      queue_pattern(s);
    end
    s = '{8'h41, 8'h42, 8'h43}; queue_pattern(s);
    while (pending_beats.size() < 400) queue_random_item(3);
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_INSERT;
    req.data_byte = '0;
    req.last_byte = 1'b0;
    res.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  req_beat_t head;
  logic req_fire = 1'b0;

  always @(posedge clk) req_fire <= !rst && req.valid && req.ready;

  always @(negedge clk) begin
    if (!rst) begin
      if (req_fire) begin
        head = pending_beats.pop_front();
        predict_beat(head);
        beats_in++;
      end
      if (!req.valid || req_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          req.valid <= 1'b0;
          stimulus_done = 1'b1;
        end else begin
          req.valid <= 1'b1;
          {req.req_type, req.data_byte, req.last_byte} <= pending_beats[0];
          if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
          end else begin
            burst_left--;
            if (burst_left == 0) gap_left = $urandom_range(1) ? $urandom_range(6) : 0;
          end
        end
      end
    end
  end

  int unsigned stall_phase = 0;

  initial begin
    wait (beats_in >= 120);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst) begin
      stall_phase++;
      if (hold_off) res.ready <= 1'b0;
      else if (stall_phase % 97 < 40) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(3) != 0);
    end
  end

  res_beat_t seen;
  res_beat_t want;

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      seen = {res.res_kind, res.insert_status, res.pattern_total, res.match_length,
              res.match_start, res.run_last};
      beats_out++;
      if (seen.res_kind == RES_MATCH) match_beats++; else insert_beats++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p.", seen);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p.", want, seen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (!rst);
    fork
      begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (3*DEPTH + 20) @(posedge clk);
      end
      wait (idle_cycles >= NODES*256 + STALL_LIMIT);
    join_any
    if (expected_results.size() != 0 || !stimulus_done) begin
      $display("Timed out with %0d results outstanding.", expected_results.size());
      $display("trie_multi_pattern_matcher_top test failed");
    end else begin
      $display("Sent %0d request beats; checked %0d insert and %0d match results.",
               beats_in, insert_beats, match_beats);
      if (mismatches == 0) $display("trie_multi_pattern_matcher_top test passed");
      else $display("trie_multi_pattern_matcher_top test failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/tmpm_pkg.sv
hdl/tmpm_req_if.sv
hdl/tmpm_res_if.sv
hdl/tmpm_ctrl.sv
hdl/tmpm_dp.sv
hdl/trie_multi_pattern_matcher_top.sv
tb/sv/trie_multi_pattern_matcher_top_test.sv
